/* rtl/core/sdma_pkg.sv */
// Package for the strided chunk DMA channels: transaction structs, command and
// register select codes, and default sizes. No dependencies.
package sdma_pkg;

    localparam int NUM_CHANNELS_DEF = 3;
    localparam int ADDR_BITS_DEF    = 32;

    // Bus commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Register selects.
    localparam logic [3:0] SEL_CONTROL    = 4'd0;
    localparam logic [3:0] SEL_CHUNK      = 4'd1;
    localparam logic [3:0] SEL_SRC_STRIDE = 4'd2;
    localparam logic [3:0] SEL_DST_STRIDE = 4'd3;
    localparam logic [3:0] SEL_COUNT      = 4'd4;
    localparam logic [3:0] SEL_SRC_BASE   = 4'd5;
    localparam logic [3:0] SEL_DST_BASE   = 4'd6;
    localparam logic [3:0] SEL_FILL       = 4'd7;
    localparam logic [3:0] SEL_ENABLE     = 4'd8;

    localparam int          FILL_MODE_BIT = 10;
    localparam int          ENABLE_BIT    = 0;
    localparam logic [31:0] COUNT_DONE    = 32'hFFFF_FFFF;
    localparam logic [3:0]  IRQ_CH2       = 4'd12;
    localparam logic [3:0]  IRQ_BASE      = 4'd13;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  channel;
        logic [3:0]  reg_select;
        logic [31:0] write_mask;
        logic [31:0] write_value;
    } sdma_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        xfer_valid;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic        use_fill;
        logic [7:0]  fill_byte;
        logic        irq_valid;
        logic [3:0]  irq_number;
        logic        busy_res;
    } sdma_rsp_t;

endpackage

/* rtl/core/sdma_core.sv */
// Channel register file and per-transaction step logic of the DMA address
// generator. Depends on sdma_pkg.
module sdma_core #(
    parameter int NUM_CHANNELS = sdma_pkg::NUM_CHANNELS_DEF,
    parameter int ADDR_BITS    = sdma_pkg::ADDR_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  sdma_pkg::sdma_req_t req,
    output sdma_pkg::sdma_rsp_t rsp
);
    import sdma_pkg::*;

    localparam int CH_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Only bit 10 of control and the low byte of fill are ever observed, and
    // addresses are only seen below ADDR_BITS, so those are stored narrow.
    logic                 fill_mode_reg  [NUM_CHANNELS];
    logic [31:0]          chunk_reg      [NUM_CHANNELS];
    logic [ADDR_BITS-1:0] src_stride_reg [NUM_CHANNELS];
    logic [ADDR_BITS-1:0] dst_stride_reg [NUM_CHANNELS];
    logic [31:0]          count_reg      [NUM_CHANNELS];
    logic [ADDR_BITS-1:0] src_base_reg   [NUM_CHANNELS];
    logic [ADDR_BITS-1:0] dst_base_reg   [NUM_CHANNELS];
    logic [7:0]           fill_reg       [NUM_CHANNELS];
    logic [31:0]          offset_reg;
    logic                 active_reg;
    logic [CH_BITS-1:0]   active_ch_reg;

    logic                 fill_mode_next;
    logic [31:0]          chunk_next;
    logic [ADDR_BITS-1:0] src_stride_next;
    logic [ADDR_BITS-1:0] dst_stride_next;
    logic [31:0]          count_next;
    logic [ADDR_BITS-1:0] src_base_next;
    logic [ADDR_BITS-1:0] dst_base_next;
    logic [7:0]           fill_next;
    logic [31:0]          offset_next;
    logic                 active_next;
    logic [CH_BITS-1:0]   active_ch_next;

    logic                 is_tick;
    logic                 ch_ok;
    logic [CH_BITS-1:0]   idx;
    logic                 upd;
    logic                 wrap;
    logic [ADDR_BITS-1:0] src_sum;
    logic [ADDR_BITS-1:0] dst_sum;
    logic [ADDR_BITS-1:0] wm;
    logic [ADDR_BITS-1:0] wv;
    logic [3:0]           irq_line;

    // A tick works on the running channel, every other command on the
    // addressed one, so each channel register has a single access point.
    assign is_tick = (req.command == CMD_TICK);
    assign ch_ok   = (int'(req.channel) < NUM_CHANNELS);
    assign idx     = is_tick ? active_ch_reg : CH_BITS'(req.channel);
    assign wm      = req.write_mask[ADDR_BITS-1:0];
    assign wv      = req.write_value[ADDR_BITS-1:0];

    // On a chunk boundary the offset equals the chunk register, so the address is base plus stride.
    assign wrap    = (offset_reg == chunk_reg[idx]);
    assign src_sum = src_base_reg[idx] + (wrap ? src_stride_reg[idx]
                                               : offset_reg[ADDR_BITS-1:0]);
    assign dst_sum = dst_base_reg[idx] + (wrap ? dst_stride_reg[idx]
                                               : offset_reg[ADDR_BITS-1:0]);
    assign irq_line = (int'(idx) == 2) ? IRQ_CH2 : 4'(IRQ_BASE + 4'(idx));

    always_comb
    begin
        fill_mode_next  = fill_mode_reg[idx];
        chunk_next      = chunk_reg[idx];
        src_stride_next = src_stride_reg[idx];
        dst_stride_next = dst_stride_reg[idx];
        count_next      = count_reg[idx];
        src_base_next   = src_base_reg[idx];
        dst_base_next   = dst_base_reg[idx];
        fill_next       = fill_reg[idx];
        offset_next     = offset_reg;
        active_next     = active_reg;
        active_ch_next  = active_ch_reg;
        upd             = 1'b0;
        rsp             = '0;

        unique case (req.command)
            CMD_WRITE:
            begin
                if (ch_ok)
                begin
                    case (req.reg_select)
                        SEL_CONTROL:
                        begin
                            upd = 1'b1;
                            if (req.write_mask[FILL_MODE_BIT])
                                fill_mode_next = req.write_value[FILL_MODE_BIT];
                        end
                        SEL_CHUNK:
                        begin
                            upd = 1'b1;
                            chunk_next = (chunk_reg[idx] & ~req.write_mask)
                                       | (req.write_value & req.write_mask);
                        end
                        SEL_SRC_STRIDE:
                        begin
                            upd = 1'b1;
                            src_stride_next = (src_stride_reg[idx] & ~wm) | (wv & wm);
                        end
                        SEL_DST_STRIDE:
                        begin
                            upd = 1'b1;
                            dst_stride_next = (dst_stride_reg[idx] & ~wm) | (wv & wm);
                        end
                        SEL_COUNT:
                        begin
                            upd = 1'b1;
                            count_next = (count_reg[idx] & ~req.write_mask)
                                       | (req.write_value & req.write_mask);
                        end
                        SEL_SRC_BASE:
                        begin
                            upd = 1'b1;
                            src_base_next = (src_base_reg[idx] & ~wm) | (wv & wm);
                        end
                        SEL_DST_BASE:
                        begin
                            upd = 1'b1;
                            dst_base_next = (dst_base_reg[idx] & ~wm) | (wv & wm);
                        end
                        SEL_FILL:
                        begin
                            upd = 1'b1;
                            fill_next = (fill_reg[idx] & ~req.write_mask[7:0])
                                      | (req.write_value[7:0] & req.write_mask[7:0]);
                        end
                        SEL_ENABLE:
                        begin
                            if (req.write_mask[ENABLE_BIT] && req.write_value[ENABLE_BIT]
                                && !active_reg)
                            begin
                                active_next    = 1'b1;
                                active_ch_next = idx;
                                offset_next    = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_READ:
            begin
                if (ch_ok)
                    rsp.read_data = count_reg[idx];
            end
            CMD_TICK:
            begin
                if (active_reg)
                begin
                    if (count_reg[idx] == COUNT_DONE)
                    begin
                        rsp.irq_valid  = 1'b1;
                        rsp.irq_number = irq_line;
                        active_next    = 1'b0;
                    end
                    else
                    begin
                        upd             = 1'b1;
                        rsp.xfer_valid  = 1'b1;
                        rsp.src_address = 32'(src_sum);
                        rsp.dst_address = 32'(dst_sum);
                        rsp.use_fill    = fill_mode_reg[idx];
                        rsp.fill_byte   = fill_mode_reg[idx] ? fill_reg[idx] : 8'd0;
                        if (wrap)
                        begin
                            src_base_next = src_sum;
                            dst_base_next = dst_sum;
                            offset_next   = 32'd1;
                        end
                        else
                        begin
                            offset_next = offset_reg + 32'd1;
                        end
                        count_next = count_reg[idx] - 32'd1;
                        // The decrement that wraps to all-ones is the last transfer.
                        if (count_reg[idx] == '0)
                        begin
                            rsp.irq_valid  = 1'b1;
                            rsp.irq_number = irq_line;
                            active_next    = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase

        rsp.busy_res = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                fill_mode_reg[i]  <= 1'b0;
                chunk_reg[i]      <= '0;
                src_stride_reg[i] <= '0;
                dst_stride_reg[i] <= '0;
                count_reg[i]      <= '0;
                src_base_reg[i]   <= '0;
                dst_base_reg[i]   <= '0;
                fill_reg[i]       <= '0;
            end
            offset_reg    <= '0;
            active_reg    <= 1'b0;
            active_ch_reg <= '0;
        end
        else if (step)
        begin
            if (upd)
            begin
                fill_mode_reg[idx]  <= fill_mode_next;
                chunk_reg[idx]      <= chunk_next;
                src_stride_reg[idx] <= src_stride_next;
                dst_stride_reg[idx] <= dst_stride_next;
                count_reg[idx]      <= count_next;
                src_base_reg[idx]   <= src_base_next;
                dst_base_reg[idx]   <= dst_base_next;
                fill_reg[idx]       <= fill_next;
            end
            offset_reg    <= offset_next;
            active_reg    <= active_next;
            active_ch_reg <= active_ch_next;
        end
    end

    a_active_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (int'(active_ch_reg) < NUM_CHANNELS))
        else $error("running channel index out of range");

    a_irq_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && rsp.irq_valid) |=> !active_reg)
        else $error("channel still running after its interrupt");

    a_xfer_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        (step && rsp.xfer_valid) |-> active_reg)
        else $error("transfer emitted with no running channel");

endmodule

/* rtl/core/sdma_out_buf.sv */
// Two-entry result buffer (output register plus skid register) that lets the
// step logic accept a transaction while a result waits. Depends on sdma_pkg.
module sdma_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  sdma_pkg::sdma_rsp_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sdma_pkg::sdma_rsp_t pop_data
);
    import sdma_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    sdma_rsp_t out_data_reg;
    sdma_rsp_t out_data_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    sdma_rsp_t skid_data_reg;
    sdma_rsp_t skid_data_next;
    logic      push;
    logic      pop;

    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = out_valid_reg && pop_ready;
    assign pop_valid  = out_valid_reg;
    assign pop_data   = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved forward after a pop");

endmodule

/* rtl/core/strided_chunk_dma_channels.sv */
// Top level of the strided chunk DMA channels: step logic and result buffer.
// Depends on sdma_pkg, sdma_core and sdma_out_buf.
//
//   Channel   Handshake             Payload      Direction
//   req       req_valid/req_ready   sdma_req_t   in: write, read count, tick
//   rsp       rsp_valid/rsp_ready   sdma_rsp_t   out: one result per request
//
// Register update, address add and chunk compare are done combinationally
// between the channel registers and the result register.
// The result of each accepted request is registered in the result buffer.
// Requests are taken every cycle; a stalled result parks in a skid entry, and
// req_ready drops only while both result entries are full.
// Reset clears all channel registers and leaves every channel idle.
module strided_chunk_dma_channels #(
    parameter int NUM_CHANNELS = sdma_pkg::NUM_CHANNELS_DEF,
    parameter int ADDR_BITS    = sdma_pkg::ADDR_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  sdma_pkg::sdma_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output sdma_pkg::sdma_rsp_t rsp
);
    import sdma_pkg::*;

    sdma_rsp_t step_rsp;
    logic      step;

    assign step = req_valid && req_ready;

    sdma_core #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .req  (req),
        .rsp  (step_rsp)
    );

    sdma_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(req_valid),
        .push_ready(req_ready),
        .push_data (step_rsp),
        .pop_valid (rsp_valid),
        .pop_ready (rsp_ready),
        .pop_data  (rsp)
    );

endmodule
